// ----- rtl/bps_pkg.sv -----
// Shared types, constants and pattern tables of the beep pattern sequencer.
`default_nettype none

package bps_pkg;

    localparam int COUNT_WIDTH_DEF = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;

    // Register reset values
    localparam logic [7:0] LONG_ON_RST      = 8'd60;
    localparam logic [7:0] LONG_OFF_RST     = 8'd20;
    localparam logic [7:0] SHORT_ON_RST     = 8'd20;
    localparam logic [7:0] SHORT_OFF_RST    = 8'd30;
    localparam logic [7:0] POWER_ON_LEN_RST = 8'd30;
    localparam logic [7:0] KEY_LEN_RST      = 8'd10;
    localparam logic [3:0] DEFER_TICKS_RST  = 4'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_ON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_OFF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_OFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFER_TICKS  = 3'd6;

    // Request function codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Pattern codes with special lengths
    localparam logic [3:0] CODE_NONE  = 4'd0;
    localparam logic [3:0] CODE_POWER = 4'd1;
    localparam logic [3:0] CODE_KEY   = 4'd2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_LONG_ON   = 3'd1,
        PH_LONG_OFF  = 3'd2,
        PH_SHORT_ON  = 3'd3,
        PH_SHORT_OFF = 3'd4
    } bps_phase_t;

    typedef struct packed {
        logic       func;
        logic [3:0] pattern_code;
    } bps_in_t;

    typedef struct packed {
        logic buzzer_on;
        logic playing;
    } bps_out_t;

    typedef struct packed {
        logic [7:0] long_on;
        logic [7:0] long_off;
        logic [7:0] short_on;
        logic [7:0] short_off;
        logic [7:0] power_on_len;
        logic [7:0] key_len;
        logic [3:0] defer_ticks;
    } bps_cfg_t;

    // Sequencer state apart from the hold counter, whose width is a parameter
    typedef struct packed {
        bps_phase_t phase;
        logic [2:0] beep_count;
        logic [3:0] active_code;
        logic [3:0] pending_code;
        logic [3:0] defer_count;
        logic       drive_level;
    } bps_state_t;

    // Number of short beeps per pattern; zero means nothing to play
    function automatic logic [2:0] pat_beeps(input logic [3:0] code);
        logic [2:0] n;
        case (code)
            4'd1, 4'd2, 4'd7, 4'd8, 4'd9: n = 3'd1;
            4'd3, 4'd10:                  n = 3'd2;
            4'd4:                         n = 3'd3;
            4'd5, 4'd6:                   n = 3'd4;
            4'd11:                        n = 3'd5;
            4'd12:                        n = 3'd6;
            default:                      n = 3'd0;
        endcase
        return n;
    endfunction

    // Long prelude beep present
    function automatic logic pat_long(input logic [3:0] code);
        logic l;
        case (code)
            4'd3, 4'd4, 4'd7, 4'd8: l = 1'b1;
            default:                l = 1'b0;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/beep_pattern_sequencer_core.sv -----
// Top level of the beep pattern sequencer: request registers, sequencer state, result register.
`default_nettype none

// Beep pattern sequencer. Each request on the s_ channel is either a 10 ms
// tick (func = 0) or a pattern request (func = 1, pattern_code 1..12; code 0
// cancels a pending request). A pattern request waits while defer_ticks
// ticks keep the buzzer silent, then plays: a single beep for the power and
// key codes, otherwise an optional long beep and gap followed by one to six
// short beeps. Every request yields exactly one result on the m_ channel with
// the buzzer level and a playing flag. Throughput is one request per clock
// while results are taken. Each goes through the input and result registers,
// and the sequencer state is updated in the single stage between them. The
// result register frees the input side as soon as the result is taken, so
// back-pressure stalls only when a result is held. Registers are written on
// cfg_we by index (0 long_on .. 6 defer_ticks) and should only be changed
// while no request is in flight. COUNT_WIDTH sets the hold counter width;
// length registers larger than its range are clamped.
module beep_pattern_sequencer_core
    import bps_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bps_in_t               s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bps_out_t                   m_data,
    // register write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    bps_cfg_t cfg;

    // input register
    logic    in_vld_reg;
    bps_in_t in_reg;

    // sequencer state
    bps_state_t             state_reg;
    bps_state_t             state_next;
    logic [COUNT_WIDTH-1:0] hold_reg;
    logic [COUNT_WIDTH-1:0] hold_next;

    // result register
    logic     out_vld_reg;
    bps_out_t out_reg;
    bps_out_t out_next;

    logic advance;

    bps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bps_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .item     (in_reg),
        .cfg      (cfg),
        .cur      (state_reg),
        .hold_cur (hold_reg),
        .nxt      (state_next),
        .hold_nxt (hold_next),
        .result   (out_next)
    );

    // A buffered request moves on when the result slot is free or being emptied
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // State commits together with the result it produced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.beep_count   <= '0;
            state_reg.active_code  <= CODE_NONE;
            state_reg.pending_code <= CODE_NONE;
            state_reg.defer_count  <= '0;
            state_reg.drive_level  <= 1'b0;
            hold_reg               <= '0;
            out_vld_reg            <= 1'b0;
        end else if (advance) begin
            state_reg   <= state_next;
            hold_reg    <= hold_next;
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/bps_cfg_regs.sv -----
// Configuration register bank of the beep pattern sequencer.
`default_nettype none

module bps_cfg_regs
    import bps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output bps_cfg_t                   cfg
);

    bps_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_on      <= LONG_ON_RST;
            cfg_reg.long_off     <= LONG_OFF_RST;
            cfg_reg.short_on     <= SHORT_ON_RST;
            cfg_reg.short_off    <= SHORT_OFF_RST;
            cfg_reg.power_on_len <= POWER_ON_LEN_RST;
            cfg_reg.key_len      <= KEY_LEN_RST;
            cfg_reg.defer_ticks  <= DEFER_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LONG_ON:      cfg_reg.long_on      <= cfg_wdata;
                CFG_LONG_OFF:     cfg_reg.long_off     <= cfg_wdata;
                CFG_SHORT_ON:     cfg_reg.short_on     <= cfg_wdata;
                CFG_SHORT_OFF:    cfg_reg.short_off    <= cfg_wdata;
                CFG_POWER_ON_LEN: cfg_reg.power_on_len <= cfg_wdata;
                CFG_KEY_LEN:      cfg_reg.key_len      <= cfg_wdata;
                CFG_DEFER_TICKS:  cfg_reg.defer_ticks  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/bps_step.sv -----
// Next-state and result logic for one tick or request.
`default_nettype none

module bps_step
    import bps_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire bps_in_t            item,
    input  wire bps_cfg_t           cfg,
    input  wire bps_state_t         cur,
    input  wire logic [COUNT_WIDTH-1:0] hold_cur,
    output bps_state_t              nxt,
    output logic [COUNT_WIDTH-1:0]  hold_nxt,
    output bps_out_t                result
);

    localparam int LW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [LW-1:0] CountMax = LW'((1 << COUNT_WIDTH) - 1);

    function automatic logic [COUNT_WIDTH-1:0] clamp_len(input logic [7:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        if (w > CountMax) begin
            w = CountMax;
        end
        return COUNT_WIDTH'(w);
    endfunction

    bps_state_t               pre;
    logic [COUNT_WIDTH-1:0]   hold_pre;
    logic                     run;
    logic [3:0]               defer_inc;
    logic [2:0]               n_beeps;
    logic [2:0]               beep_inc;
    logic [COUNT_WIDTH:0]     hold_inc;
    logic [COUNT_WIDTH-1:0]   beep_len;

    // Request handling and deferral
    always_comb begin
        pre       = cur;
        hold_pre  = hold_cur;
        run       = 1'b0;
        defer_inc = cur.defer_count + 4'd1;
        if (item.func == FUNC_REQUEST) begin
            pre.pending_code = item.pattern_code;
        end else if (cur.pending_code != CODE_NONE) begin
            // pending: silence and stop whatever runs
            pre.phase       = PH_IDLE;
            hold_pre        = '0;
            pre.beep_count  = '0;
            pre.active_code = CODE_NONE;
            pre.drive_level = 1'b0;
            pre.defer_count = defer_inc;
            if (defer_inc >= cfg.defer_ticks) begin
                pre.defer_count  = '0;
                pre.active_code  = cur.pending_code;
                pre.pending_code = CODE_NONE;
                pre.phase        = pat_long(cur.pending_code) ? PH_LONG_ON : PH_SHORT_ON;
                run              = 1'b1;
            end
        end else if (cur.active_code != CODE_NONE) begin
            run = 1'b1;
        end
    end

    // One tick of the running pattern
    always_comb begin
        nxt      = pre;
        hold_nxt = hold_pre;
        n_beeps  = pat_beeps(pre.active_code);
        beep_inc = pre.beep_count + 3'd1;
        hold_inc = {1'b0, hold_pre} + {{COUNT_WIDTH{1'b0}}, 1'b1};
        case (pre.active_code)
            CODE_POWER: beep_len = clamp_len(cfg.power_on_len);
            CODE_KEY:   beep_len = clamp_len(cfg.key_len);
            default:    beep_len = clamp_len(cfg.short_on);
        endcase
        if (run) begin
            if (n_beeps == 3'd0) begin
                nxt.phase       = PH_IDLE;
                hold_nxt        = '0;
                nxt.beep_count  = '0;
                nxt.active_code = CODE_NONE;
                nxt.drive_level = 1'b0;
            end else begin
                case (pre.phase)
                    PH_LONG_ON: begin
                        if (hold_inc > {1'b0, clamp_len(cfg.long_on)}) begin
                            hold_nxt        = '0;
                            nxt.phase       = PH_LONG_OFF;
                            nxt.drive_level = 1'b0;
                        end else begin
                            hold_nxt        = hold_inc[COUNT_WIDTH-1:0];
                            nxt.drive_level = 1'b1;
                        end
                    end
                    PH_LONG_OFF: begin
                        if (hold_inc >= {1'b0, clamp_len(cfg.long_off)}) begin
                            nxt.phase       = PH_SHORT_ON;
                            hold_nxt        = COUNT_WIDTH'(1);
                            nxt.drive_level = 1'b1;
                        end else begin
                            hold_nxt = hold_inc[COUNT_WIDTH-1:0];
                        end
                    end
                    PH_SHORT_ON: begin
                        if (hold_inc > {1'b0, beep_len}) begin
                            hold_nxt       = '0;
                            nxt.beep_count = beep_inc;
                            if (beep_inc >= n_beeps) begin
                                nxt.phase       = PH_IDLE;
                                nxt.beep_count  = '0;
                                nxt.active_code = CODE_NONE;
                                nxt.drive_level = 1'b0;
                            end else begin
                                nxt.phase       = PH_SHORT_OFF;
                                nxt.drive_level = 1'b0;
                            end
                        end else begin
                            hold_nxt        = hold_inc[COUNT_WIDTH-1:0];
                            nxt.drive_level = 1'b1;
                        end
                    end
                    PH_SHORT_OFF: begin
                        if (hold_inc >= {1'b0, clamp_len(cfg.short_off)}) begin
                            nxt.phase       = PH_SHORT_ON;
                            hold_nxt        = COUNT_WIDTH'(1);
                            nxt.drive_level = 1'b1;
                        end else begin
                            hold_nxt = hold_inc[COUNT_WIDTH-1:0];
                        end
                    end
                    default: begin
                        nxt.phase       = PH_IDLE;
                        hold_nxt        = '0;
                        nxt.beep_count  = '0;
                        nxt.active_code = CODE_NONE;
                        nxt.drive_level = 1'b0;
                    end
                endcase
            end
        end
        result.buzzer_on = nxt.drive_level;
        result.playing   = (nxt.active_code != CODE_NONE) || (nxt.pending_code != CODE_NONE);
    end

endmodule

`default_nettype wire
